/* rtl/swmf_pkg.sv */
// Package of the sliding window median filter: widths, defaults, state and control types.
package swmf_pkg;

	// Default configuration of the window
	localparam int WINDOW_DEF      = 15;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed result field widths
	localparam int MEDIAN_W = 17;
	localparam int USED_W   = 4;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	// Control from the sequencer to the rank selectors
	typedef struct packed {
		logic start;
		logic step;
	} sel_ctrl_t;

endpackage

/* rtl/swmf_in_if.sv */
// Sample channel of the median filter: valid, ready and one signed sample.
interface swmf_in_if #(
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/swmf_out_if.sv */
// Result channel of the median filter: valid, ready, doubled median and sample count.
interface swmf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [swmf_pkg::MEDIAN_W-1:0] median_doubled;
	logic        [swmf_pkg::USED_W-1:0]   samples_used;

	modport source (output valid, output median_doubled, output samples_used, input ready);
	modport sink   (input valid, input median_doubled, input samples_used, output ready);
endinterface

/* rtl/sliding_window_median_filter.sv */
// Top level of the sliding window median filter: sequencer, window, two rank selectors, output.
//
//  channel  role    payload                          handshake
//  feed     sink    sample (SAMPLE_BITS, signed)     valid/ready, taken on both high
//  result   source  median_doubled (17, signed),     valid/ready, taken on both high
//                   samples_used (4, unsigned)
//
// An item is handled in order: the sample is taken, the two bit-serial rank selectors walk
// the window MSB first, one sample bit at a time, and then the two middle values are added.
// Reset (arst_n low) marks the window empty, without clearing its rows, and clears the control state at once.
// The output register holds a finished result while the next sample is taken; a stalled
// result only holds the sequencer once a second result is ready to leave.
module sliding_window_median_filter #(
	parameter int WINDOW      = swmf_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	swmf_in_if.sink   feed,
	swmf_out_if.source result
);
	import swmf_pkg::*;

	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int BIT_W  = $clog2(SAMPLE_BITS);
	localparam int SUM_W  = SAMPLE_BITS + 1;
	localparam int WIDE_W = (SUM_W > MEDIAN_W) ? SUM_W : MEDIAN_W;
	localparam int USED_X = (CNT_W > USED_W) ? CNT_W : USED_W;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         slot_q;
	logic                     filled_q;
	logic [CNT_W-1:0]         count_q;
	logic [BIT_W-1:0]         bit_q;
	logic                     out_valid_q;
	logic signed [MEDIAN_W-1:0] median_q;
	logic [USED_W-1:0]        used_q;

	logic                     take;
	logic                     emit;
	logic                     scan;
	logic [CNT_W-1:0]         slot_inc;
	logic                     wrap;
	logic [CNT_W-1:0]         count_d;
	logic [CNT_W-1:0]         mid;
	logic [CNT_W-1:0]         rank_lo;
	logic [WINDOW-1:0]        msbs;
	logic [WINDOW-1:0]        bits;
	sel_ctrl_t                ctrl;
	logic signed [SAMPLE_BITS-1:0] val_lo, val_hi;
	logic signed [SUM_W-1:0]  sum;
	logic signed [WIDE_W-1:0] sum_wide;
	logic [USED_X-1:0]        used_wide;

	// Handshakes
	assign feed.ready = (state_q == ST_IDLE);
	assign take       = feed.valid && feed.ready;
	assign scan       = (state_q == ST_SCAN);

	// Next slot, fill flag and sample count after this item
	assign slot_inc = slot_q + CNT_W'(1);
	assign wrap     = (slot_inc == CNT_W'(WINDOW));
	assign count_d  = (filled_q || wrap) ? CNT_W'(WINDOW) : slot_inc;
	assign mid      = count_d >> 1;
	assign rank_lo  = count_d[0] ? mid : mid - CNT_W'(1);

	// Next state and outputs
	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (bit_q == BIT_W'(SAMPLE_BITS - 1)) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || result.ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the write slot and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			filled_q <= 1'b0;
			count_q  <= '0;
			bit_q    <= '0;
		end else begin
			if (take) begin
				slot_q   <= wrap ? '0 : slot_inc;
				filled_q <= filled_q || wrap;
				count_q  <= count_d;
				bit_q    <= '0;
			end else if (scan) begin
				bit_q <= bit_q + BIT_W'(1);
			end
		end
	end

	// Window and selectors; flip the sign bit so plain bit order sorts signed values
	assign ctrl.start = take;
	assign ctrl.step  = scan;
	assign bits       = msbs ^ {WINDOW{bit_q == '0}};

	swmf_window #(
		.WINDOW     (WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CNT_W      (CNT_W)
	) u_window (
		.clk  (clk),
		.load (take),
		.slot (slot_q),
		.data (feed.sample),
		.shift(scan),
		.msbs (msbs)
	);

	swmf_rank_select #(
		.WINDOW     (WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CNT_W      (CNT_W)
	) u_sel_lo (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.rank  (rank_lo),
		.count (count_d),
		.bits  (bits),
		.value (val_lo)
	);

	swmf_rank_select #(
		.WINDOW     (WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CNT_W      (CNT_W)
	) u_sel_hi (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.rank  (mid),
		.count (count_d),
		.bits  (bits),
		.value (val_hi)
	);

	// Add the two middle values; an odd count selects the same one twice
	assign sum       = SUM_W'(val_lo) + SUM_W'(val_hi);
	assign sum_wide  = WIDE_W'(sum);
	assign used_wide = USED_X'(count_q);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			median_q <= sum_wide[MEDIAN_W-1:0];
			used_q   <= used_wide[USED_W-1:0];
		end
	end

	assign result.valid          = out_valid_q;
	assign result.median_doubled = median_q;
	assign result.samples_used   = used_q;

endmodule

/* rtl/swmf_window.sv */
// Sample window held as rotating shift registers that present one bit per row each cycle while shift is high.
module swmf_window #(
	parameter int WINDOW      = swmf_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = $clog2(WINDOW + 1)
) (
	input  logic                   clk,
	input  logic                   load,
	input  logic [CNT_W-1:0]       slot,
	input  logic [SAMPLE_BITS-1:0] data,
	input  logic                   shift,
	output logic [WINDOW-1:0]      msbs
);
	import swmf_pkg::*;

	logic [SAMPLE_BITS-1:0] row_q [WINDOW];

	// Load the addressed row, or rotate every row left by one bit
	for (genvar i = 0; i < WINDOW; i++) begin : g_row
		always_ff @(posedge clk) begin
			if (load && slot == CNT_W'(i)) begin
				row_q[i] <= data;
			end else if (shift) begin
				row_q[i] <= {row_q[i][SAMPLE_BITS-2:0], row_q[i][SAMPLE_BITS-1]};
			end
		end
		assign msbs[i] = row_q[i][SAMPLE_BITS-1];
	end

endmodule

/* rtl/swmf_rank_select.sv */
// Bit-serial rank selector: finds the k-th smallest held sample, MSB first.
module swmf_rank_select #(
	parameter int WINDOW      = swmf_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = $clog2(WINDOW + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swmf_pkg::sel_ctrl_t           ctrl,
	input  logic [CNT_W-1:0]              rank,
	input  logic [CNT_W-1:0]              count,
	input  logic [WINDOW-1:0]             bits,
	output logic signed [SAMPLE_BITS-1:0] value
);
	import swmf_pkg::*;

	logic [WINDOW-1:0]      cand_q;
	logic [CNT_W-1:0]       rank_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic [WINDOW-1:0]      cand_init;
	logic [WINDOW-1:0]      zeros;
	logic [CNT_W-1:0]       zero_cnt;
	logic                   pick_one;

	// Only slots below the count take part
	for (genvar i = 0; i < WINDOW; i++) begin : g_init
		assign cand_init[i] = CNT_W'(i) < count;
	end

	// Count candidates with a zero in this bit; the rank decides the result bit
	assign zeros    = cand_q & ~bits;
	assign zero_cnt = CNT_W'($countones(zeros));
	assign pick_one = rank_q >= zero_cnt;

	// Narrow the candidate set and the remaining rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			rank_q <= '0;
		end else if (ctrl.start) begin
			cand_q <= cand_init;
			rank_q <= rank;
		end else if (ctrl.step) begin
			if (pick_one) begin
				cand_q <= cand_q & bits;
				rank_q <= rank_q - zero_cnt;
			end else begin
				cand_q <= zeros;
			end
		end
	end

	// Collect result bits, MSB first
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			res_q <= {res_q[SAMPLE_BITS-2:0], pick_one};
		end
	end

	// Undo the sign bit offset
	assign value = {~res_q[SAMPLE_BITS-1], res_q[SAMPLE_BITS-2:0]};

endmodule
